// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round helpers for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam int unsigned BLOCK_BYTES = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_RUN,
        ST_OUT
    } sha1_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       write_byte;  // store data byte at fill, bump counters
        logic       write_pad;   // store pad byte (mark/zero/length) at fill
        logic       pad_mark;    // pad byte is the 0x80 mark
        logic       start_run;   // load working vars from chain, round 0
        logic       round_en;    // one round
        logic       finish_run;  // add working vars into chain
        logic       reinit;      // reset chain and counters
    } sha1_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [5:0] fill;
        logic       last_round;
    } sha1_stat_t;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        rol32 = (x << n) | (x >> (32 - n));
    endfunction

endpackage

// ===== rtl/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Streaming SHA-1 hasher, one message byte per item, five digest words out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry data_byte, byte_valid, last_byte.
// byte_valid=0 with last_byte=1 closes the message without adding a byte.
// Output channel: out_valid/out_stall carry digest_word, word_index and
// last_word; five items per message, word 0 first, last_word on word 4.
// Intake: a byte that does not complete a block is accepted without a stall.
// The byte that completes a block holds in_stall while the block is
// compressed (load, 80 rounds, add); no new byte is taken until the add.
// Closing pads one byte per cycle to the end of the block and compresses;
// with fewer than 9 bytes of room a second block is padded and compressed.
// The digest words then follow, one word per cycle while out_stall is low.
// While compressing, padding or presenting the digest, in_stall is high.
// A stalled output holds its word until taken; the block then reinitializes.
// Reset clears the chaining words to the standard initial values and the
// byte counters to zero; the block buffer needs no clearing.
module sha1_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1_pkg::*;

    sha1_cmd_t  cmd;
    sha1_stat_t stat;
    logic       pad_length;

    sha1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_index (word_index),
        .last_word  (last_word),
        .cmd        (cmd),
        .pad_length (pad_length),
        .stat       (stat)
    );

    sha1_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .pad_length (pad_length),
        .stat       (stat),
        .rd_index   (word_index),
        .rd_word    (digest_word)
    );

endmodule

// ===== rtl/sha1_datapath.sv =====
// ----------------------------------------------------------------------------
// sha1_datapath
// Block buffer, message schedule, round logic and chaining words.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::sha1_cmd_t cmd,
    input  logic [7:0]          data_byte,
    input  logic                pad_length,   // length phase of padding
    output sha1_pkg::sha1_stat_t stat,
    input  logic [2:0]          rd_index,
    output logic [31:0]         rd_word
);
    import sha1_pkg::*;

    logic [5:0]  fill_reg;
    logic [60:0] msg_bytes_reg;
    logic [6:0]  round_reg;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    // 16-word sliding schedule window; word 0 is w[t]
    logic [31:0] w_reg [16];

    logic [63:0] bit_len;
    logic [7:0]  pad_byte;
    logic [7:0]  wr_byte;
    logic [31:0] w_new;
    logic [31:0] f_val, k_val, tmp;

    assign bit_len = {msg_bytes_reg, 3'b000};

    // length bytes occupy positions 56..63, big-endian
    always_comb
    begin
        pad_byte = 8'h00;
        if (cmd.pad_mark)
        begin
            pad_byte = PAD_MARK;
        end
        else if (pad_length && fill_reg[5:3] == 3'd7)
        begin
            pad_byte = bit_len[8*(7 - fill_reg[2:0]) +: 8];
        end
    end

    assign wr_byte = cmd.write_byte ? data_byte : pad_byte;

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = 32'h5A827999;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = 32'h6ED9EBA1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = 32'h8F1BBCDC;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = 32'hCA62C1D6;
        end
        tmp   = rol32(a_reg, 5) + f_val + e_reg + k_val + w_reg[0];
        w_new = rol32(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            msg_bytes_reg <= '0;
            round_reg     <= '0;
            h_reg[0] <= IV0;
            h_reg[1] <= IV1;
            h_reg[2] <= IV2;
            h_reg[3] <= IV3;
            h_reg[4] <= IV4;
        end
        else
        begin
            if (cmd.write_byte || cmd.write_pad)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.write_byte)
            begin
                msg_bytes_reg <= msg_bytes_reg + 61'd1;
            end
            if (cmd.start_run)
            begin
                round_reg <= 7'd0;
            end
            else if (cmd.round_en)
            begin
                round_reg <= round_reg + 7'd1;
            end
            if (cmd.finish_run)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (cmd.reinit)
            begin
                fill_reg      <= '0;
                msg_bytes_reg <= '0;
                h_reg[0] <= IV0;
                h_reg[1] <= IV1;
                h_reg[2] <= IV2;
                h_reg[3] <= IV3;
                h_reg[4] <= IV4;
            end
        end
    end

    // working variables and schedule window: payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte || cmd.write_pad)
        begin
            w_reg[fill_reg[5:2]][8*(3 - fill_reg[1:0]) +: 8] <= wr_byte;
        end
        if (cmd.start_run)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round_en)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= rol32(b_reg, 30);
            b_reg <= a_reg;
            a_reg <= tmp;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    assign stat.fill       = fill_reg;
    assign stat.last_round = (round_reg == 7'd80);
    assign rd_word = h_reg[rd_index];

endmodule

// ===== rtl/sha1_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer for byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 byte_valid,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           word_index,
    output logic                 last_word,
    output sha1_pkg::sha1_cmd_t  cmd,
    output logic                 pad_length,
    input  sha1_pkg::sha1_stat_t stat
);
    import sha1_pkg::*;

    sha1_state_t state_reg, state_next;
    logic        closing_reg, closing_next;   // message end pending
    logic        len_reg, len_next;           // current block carries the length
    logic        mark_reg, mark_next;         // pad mark already written
    logic [2:0]  idx_reg, idx_next;
    logic        run_first_reg, run_first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            closing_reg   <= 1'b0;
            len_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            idx_reg       <= '0;
            run_first_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            closing_reg   <= closing_next;
            len_reg       <= len_next;
            mark_reg      <= mark_next;
            idx_reg       <= idx_next;
            run_first_reg <= run_first_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        closing_next   = closing_reg;
        len_next       = len_reg;
        mark_next      = mark_reg;
        idx_next       = idx_reg;
        run_first_next = 1'b0;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.write_byte = byte_valid;
                    closing_next   = last_byte;
                    len_next       = 1'b0;
                    mark_next      = 1'b0;
                    if (byte_valid && stat.fill == 6'd63)
                    begin
                        state_next     = ST_RUN;
                        run_first_next = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // mark byte at current fill; ST_LEN fills the rest with zeros (and the length, if it fits)
                cmd.write_pad = 1'b1;
                cmd.pad_mark  = 1'b1;
                mark_next     = 1'b1;
                len_next      = (stat.fill < 6'd56);
                state_next    = ST_LEN;
                if (stat.fill == 6'd63)
                begin
                    state_next     = ST_RUN;
                    run_first_next = 1'b1;
                end
            end
            ST_LEN:
            begin
                cmd.write_pad = 1'b1;
                if (stat.fill == 6'd63)
                begin
                    state_next     = ST_RUN;
                    run_first_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (run_first_reg)
                begin
                    cmd.start_run = 1'b1;
                end
                else if (stat.last_round)
                begin
                    cmd.finish_run = 1'b1;
                    if (!closing_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (len_reg)
                    begin
                        state_next = ST_OUT;
                        idx_next   = '0;
                    end
                    else if (!mark_reg)
                    begin
                        // last byte filled the block: pad a fresh one
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        // no room for the length: zero block plus length
                        state_next = ST_LEN;
                        len_next   = 1'b1;
                    end
                end
                else
                begin
                    cmd.round_en = 1'b1;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd4)
                    begin
                        cmd.reinit   = 1'b1;
                        closing_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pad_length = len_reg;
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd4);

    a_out_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> idx_reg <= 3'd4)
        else $error("digest index out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(idx_reg))
        else $error("stalled digest item changed");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");

    a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_byte && cmd.write_pad))
        else $error("byte and pad written together");

endmodule
